>>> hw/rtl/rlv_pkg.sv
package rlv_pkg;

  // Default binary point of the Q-format fields
  localparam int unsigned FracBitsDef = 16;

  // Width of one vector component and of one quotient
  localparam int unsigned QW = 32;

  // Packed item width and its byte-padded stream width
  localparam int unsigned ItemW = 2 + 9 * QW;
  localparam int unsigned DataW = ((ItemW + 7) / 8) * 8;

  // 2*pi in Q4.60, rounded down
  localparam logic [63:0] TwoPiQ60 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DEGEN = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_MIN_VOLUME = 1'b0,
    REG_MIN_LEN_SQ = 1'b1
  } reg_idx_e;

endpackage

>>> hw/rtl/reciprocal_lattice_vectors_unit.sv
// Reciprocal lattice unit: takes one lattice per transaction (a count of
// 0..3 vectors, components signed Q.FRAC_BITS) and returns g0..g2 with a
// status, at one transaction per clock unless the output stalls. Path:
// 3-stage chunked multipliers for a0 x a1, a1 x a2 / a2 x a0, the triple
// product and the 2*pi scaling, one register each for the differences,
// sums and operand select, a 33-stage divider resolving one quotient bit
// per stage (plus an overflow stage) and the output register. A stall on
// the output side freezes every stage. Thresholds must be written on the cfg
// port while no transaction is in flight; the block does not enforce this.
module reciprocal_lattice_vectors_unit #(
  parameter int unsigned FRAC_BITS = rlv_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: vector_count[1:0], a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
  //        a2_x, a2_y, a2_z (32 bits each), zero pad
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rlv_pkg::DataW-1:0]  s_axis_tdata,
  // tdata: status[1:0], g0_x, g0_y, g0_z, g1_x, g1_y, g1_z,
  //        g2_x, g2_y, g2_z (32 bits each), zero pad
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rlv_pkg::DataW-1:0]  m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [30:0]                cfg_wdata_i
);

  import rlv_pkg::*;

  // exact widths of the intermediate integers
  localparam int unsigned XW   = 2 * QW + 1;      // a0 x a1
  localparam int unsigned DotW = 2 * QW + 2;      // a0 . a0
  localparam int unsigned PBW  = QW + XW;         // product in a1 x a2
  localparam int unsigned NW   = PBW + 1;         // numerator (cross component)
  localparam int unsigned PCW  = QW + NW;         // product in the triple product
  localparam int unsigned DW   = PCW + 2;         // denominator (volume)
  localparam int unsigned KW   = 64;
  localparam int unsigned PW   = NW + 1 + KW;     // |n| * 2pi
  localparam int unsigned SH   = 59 - 2 * FRAC_BITS;
  localparam int unsigned PSW  = PW - SH;
  localparam int unsigned AW   = ((PSW > DW) ? PSW : DW) + 1;
  localparam int unsigned BW   = DW + 1;

  // stage times, counted in registers after acceptance
  localparam int unsigned DivLat = QW + 1;
  localparam int unsigned TEnd   = 17 + DivLat;
  localparam int unsigned Lat    = TEnd + 1;

  localparam logic [QW-1:0] SatPos = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SatNeg = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [8:0] neg;
    status_e    st;
  } side_t;

  function automatic logic signed [QW-1:0] fld(input logic [ItemW-1:0] v,
                                               input int unsigned idx);
    return v[2 + QW*idx +: QW];
  endfunction

  logic                    pipe_en;
  logic [Lat:1]            vld_q;
  logic [30:0]             min_vol_q;
  logic [30:0]             min_len_q;

  logic signed [QW-1:0]    in_a [3][3];
  logic signed [QW-1:0]    a4 [3][3];
  logic signed [QW-1:0]    a8 [3];
  logic [ItemW-1:0]        din_q [1:12];

  logic signed [2*QW-1:0]  xp [3];
  logic signed [2*QW-1:0]  xn [3];
  logic signed [2*QW-1:0]  sq [3];
  logic signed [XW-1:0]    x_d [3];
  logic signed [XW-1:0]    x_q [4:12][3];
  logic signed [DotW-1:0]  dot_d;
  logic signed [DotW-1:0]  dot_q [4:12];

  logic signed [XW-1:0]    a2sel [3];
  logic signed [PBW-1:0]   cp [2][3];
  logic signed [PBW-1:0]   cn [2][3];
  logic signed [NW-1:0]    c_d [2][3];
  logic signed [NW-1:0]    c_q [8:12][2][3];

  logic signed [PCW-1:0]   vp [3];
  logic signed [DW-1:0]    v_d;
  logic signed [DW-1:0]    v_q;

  logic [NW-1:0]           nmag_d [9];
  logic [NW-1:0]           nmag_q [9];
  logic [DW-1:0]           dmag_d;
  logic [DW-1:0]           dmag_q [13:16];
  side_t                   side_d;
  side_t                   side_q [13:TEnd];

  logic signed [PW-1:0]    prod [9];
  logic [AW-1:0]           a_d [9];
  logic [AW-1:0]           a_q [9];
  logic [BW-1:0]           b_d;
  logic [BW-1:0]           b_q;

  logic [QW-1:0]           dq [9];
  logic                    dsat [9];
  logic [DataW-1:0]        out_d;
  logic [DataW-1:0]        out_q;

  // global stall: every stage moves when the output register can move
  assign pipe_en       = ~vld_q[Lat] | m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = vld_q[Lat];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[Lat-1:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_vol_q <= 31'd1;
      min_len_q <= 31'd1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_VOLUME: min_vol_q <= cfg_wdata_i;
        REG_MIN_LEN_SQ: min_len_q <= cfg_wdata_i;
        default:        min_vol_q <= min_vol_q;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        in_a[i][k] = fld(s_axis_tdata[ItemW-1:0], 3*i + k);
        a4[i][k]   = fld(din_q[4], 3*i + k);
      end
      a8[i] = fld(din_q[8], i);
    end
  end

  // a2 is the cross product a0 x a1 when only two vectors are given
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a2sel[k] = (din_q[4][1:0] == 2'd2) ? x_q[4][k] : XW'(a4[2][k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int unsigned K1 = (k + 1) % 3;
    localparam int unsigned K2 = (k + 2) % 3;

    // a0 x a1 and a0 . a0
    rlv_mul #(.WA(QW), .WB(QW)) u_xp (
      .clk_i, .en_i(pipe_en), .a_i(in_a[0][K1]), .b_i(in_a[1][K2]), .p_o(xp[k]));
    rlv_mul #(.WA(QW), .WB(QW)) u_xn (
      .clk_i, .en_i(pipe_en), .a_i(in_a[0][K2]), .b_i(in_a[1][K1]), .p_o(xn[k]));
    rlv_mul #(.WA(QW), .WB(QW)) u_sq (
      .clk_i, .en_i(pipe_en), .a_i(in_a[0][k]), .b_i(in_a[0][k]), .p_o(sq[k]));

    // c0 = a1 x a2, c1 = a2 x a0
    rlv_mul #(.WA(XW), .WB(QW)) u_c0p (
      .clk_i, .en_i(pipe_en), .a_i(a2sel[K2]), .b_i(a4[1][K1]), .p_o(cp[0][k]));
    rlv_mul #(.WA(XW), .WB(QW)) u_c0n (
      .clk_i, .en_i(pipe_en), .a_i(a2sel[K1]), .b_i(a4[1][K2]), .p_o(cn[0][k]));
    rlv_mul #(.WA(XW), .WB(QW)) u_c1p (
      .clk_i, .en_i(pipe_en), .a_i(a2sel[K1]), .b_i(a4[0][K2]), .p_o(cp[1][k]));
    rlv_mul #(.WA(XW), .WB(QW)) u_c1n (
      .clk_i, .en_i(pipe_en), .a_i(a2sel[K2]), .b_i(a4[0][K1]), .p_o(cn[1][k]));

    // triple product terms a0 . c0
    rlv_mul #(.WA(NW), .WB(QW)) u_v (
      .clk_i, .en_i(pipe_en), .a_i(c_q[8][0][k]), .b_i(a8[k]), .p_o(vp[k]));
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_d[k]    = XW'(xp[k]) - XW'(xn[k]);
      c_d[0][k] = NW'(cp[0][k]) - NW'(cn[0][k]);
      c_d[1][k] = NW'(cp[1][k]) - NW'(cn[1][k]);
    end
    dot_d = DotW'(sq[0]) + DotW'(sq[1]) + DotW'(sq[2]);
    v_d   = DW'(vp[0]) + DW'(vp[1]) + DW'(vp[2]);
  end

  // operand select, magnitudes, sign and degeneracy check
  always_comb begin
    logic [1:0]             cnt;
    logic signed [NW-1:0]   n [9];
    logic signed [DW-1:0]   d;
    logic [QW-1:0]          thr;
    logic [DW-1:0]          lim;
    int unsigned            sh;
    cnt = din_q[12][1:0];
    for (int k = 0; k < 3; k++) begin
      if (cnt == 2'd1) begin
        n[k]     = NW'(fld(din_q[12], k));
        n[3 + k] = '0;
        n[6 + k] = '0;
      end else begin
        n[k]     = c_q[12][0][k];
        n[3 + k] = c_q[12][1][k];
        n[6 + k] = (cnt == 2'd3) ? NW'(x_q[12][k]) : '0;
      end
    end
    d = (cnt == 2'd1) ? DW'(dot_q[12]) : v_q;
    for (int l = 0; l < 9; l++) begin
      nmag_d[l]     = n[l][NW-1] ? NW'(-n[l]) : NW'(n[l]);
      side_d.neg[l] = n[l][NW-1] ^ d[DW-1];
    end
    dmag_d = d[DW-1] ? DW'(-d) : DW'(d);
    thr = ((cnt == 2'd1) ? {1'b0, min_len_q} : {1'b0, min_vol_q}) + QW'(1);
    case (cnt)
      2'd1:    sh = FRAC_BITS;
      2'd2:    sh = 3 * FRAC_BITS;
      default: sh = 2 * FRAC_BITS;
    endcase
    lim = DW'(thr) << sh;
    // |d| < lim checked on the signed value, no magnitude in the path
    if (cnt == 2'd0) begin
      side_d.st = ST_EMPTY;
    end else if (d < $signed(lim) && d > -$signed(lim)) begin
      side_d.st = ST_DEGEN;
    end else begin
      side_d.st = ST_OK;
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_lane
    rlv_mul #(.WA(NW + 1), .WB(KW)) u_k (
      .clk_i, .en_i(pipe_en), .a_i({1'b0, nmag_q[l]}), .b_i(TwoPiQ60), .p_o(prod[l]));
  end

  // round half up: q = floor((|d| + (|n|*2pi >> SH)) / (2|d|))
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      a_d[l] = AW'(dmag_q[16]) + AW'(prod[l][PW-1:SH]);
    end
    b_d = {dmag_q[16], 1'b0};
  end

  rlv_div #(.LANES(9), .AW(AW), .BW(BW)) u_div (
    .clk_i,
    .en_i  (pipe_en),
    .a_i   (a_q),
    .b_i   (b_q),
    .q_o   (dq),
    .sat_o (dsat)
  );

  // sign, saturation and status gating
  always_comb begin
    logic [QW-1:0] g;
    out_d      = '0;
    out_d[1:0] = side_q[TEnd].st;
    for (int l = 0; l < 9; l++) begin
      if (side_q[TEnd].neg[l]) begin
        g = (dsat[l] || dq[l] > SatNeg) ? SatNeg : QW'(0) - dq[l];
      end else begin
        g = (dsat[l] || dq[l][QW-1]) ? SatPos : dq[l];
      end
      if (side_q[TEnd].st != ST_OK) begin
        g = '0;
      end
      out_d[2 + QW*l +: QW] = g;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      din_q[1] <= s_axis_tdata[ItemW-1:0];
      for (int t = 2; t <= 12; t++) din_q[t] <= din_q[t-1];
      x_q[4]   <= x_d;
      dot_q[4] <= dot_d;
      for (int t = 5; t <= 12; t++) begin
        x_q[t]   <= x_q[t-1];
        dot_q[t] <= dot_q[t-1];
      end
      c_q[8] <= c_d;
      for (int t = 9; t <= 12; t++) c_q[t] <= c_q[t-1];
      v_q        <= v_d;
      nmag_q     <= nmag_d;
      dmag_q[13] <= dmag_d;
      for (int t = 14; t <= 16; t++) dmag_q[t] <= dmag_q[t-1];
      side_q[13] <= side_d;
      for (int t = 14; t <= TEnd; t++) side_q[t] <= side_q[t-1];
      a_q   <= a_d;
      b_q   <= b_d;
      out_q <= out_d;
    end
  end

  // an accepted transaction enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[1])
    else $error("accepted transaction missing from first stage");

  // a stall freezes the whole pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // empty or degenerate results carry all-zero vectors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK)) |-> (m_axis_tdata[ItemW-1:2] == '0))
    else $error("nonzero vectors with non-ok status");

endmodule

>>> hw/rtl/rlv_mul.sv
// Signed multiplier cut into 32-bit chunks: partial products, row sums,
// final sum. Three register stages, all held while en_i is low.
module rlv_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned NA = (WA + 31) / 32;
  localparam int unsigned NB = (WB + 31) / 32;
  localparam int unsigned PW = WA + WB;

  logic signed [32*NA-1:0] ax;
  logic signed [32*NB-1:0] bx;
  logic signed [32:0]      ca [NA];
  logic signed [32:0]      cb [NB];
  logic signed [65:0]      pp_d [NA][NB];
  logic signed [65:0]      pp_q [NA][NB];
  logic signed [PW-1:0]    row_d [NA];
  logic signed [PW-1:0]    row_q [NA];
  logic signed [PW-1:0]    p_d;
  logic signed [PW-1:0]    p_q;

  assign ax = (32*NA)'(a_i);
  assign bx = (32*NB)'(b_i);

  // lower chunks are unsigned, the top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ca[i] = (i == NA - 1) ? {ax[32*i+31], ax[32*i +: 32]} : {1'b0, ax[32*i +: 32]};
    end
    for (int j = 0; j < NB; j++) begin
      cb[j] = (j == NB - 1) ? {bx[32*j+31], bx[32*j +: 32]} : {1'b0, bx[32*j +: 32]};
    end
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i][j] = ca[i] * cb[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    p_d = '0;
    for (int i = 0; i < NA; i++) begin
      p_d = p_d + (row_q[i] << (32 * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/rlv_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Stage 0 flags quotients of 2^QW or more.
module rlv_div #(
  parameter int unsigned LANES = 9,
  parameter int unsigned AW    = 163,
  parameter int unsigned BW    = 133
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [AW-1:0]            a_i [LANES],
  input  logic [BW-1:0]            b_i,
  output logic [rlv_pkg::QW-1:0]   q_o [LANES],
  output logic                     sat_o [LANES]
);

  import rlv_pkg::*;

  localparam int unsigned NST = QW + 1;
  localparam int unsigned HW  = AW - QW;
  localparam int unsigned CW  = (HW > BW) ? HW : BW;

  logic [BW-1:0] b_d   [NST];
  logic [BW-1:0] b_q   [NST];
  logic [BW-1:0] r_d   [NST][LANES];
  logic [BW-1:0] r_q   [NST][LANES];
  logic [QW-1:0] lo_d  [NST][LANES];
  logic [QW-1:0] lo_q  [NST][LANES];
  logic          sat_d [NST][LANES];
  logic          sat_q [NST][LANES];

  always_comb begin
    logic [BW:0] t;
    logic        ge;
    b_d[0] = b_i;
    for (int l = 0; l < LANES; l++) begin
      sat_d[0][l] = CW'(a_i[l][AW-1:QW]) >= CW'(b_i);
      r_d[0][l]   = BW'(a_i[l][AW-1:QW]);
      lo_d[0][l]  = a_i[l][QW-1:0];
    end
    for (int s = 1; s < NST; s++) begin
      b_d[s] = b_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        // remainder stays below the divisor; dividend bits shift out, quotient bits in
        t  = {r_q[s-1][l], lo_q[s-1][l][QW-1]};
        ge = t >= {1'b0, b_q[s-1]};
        r_d[s][l]   = ge ? BW'(t - {1'b0, b_q[s-1]}) : BW'(t);
        lo_d[s][l]  = {lo_q[s-1][l][QW-2:0], ge};
        sat_d[s][l] = sat_q[s-1][l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q   <= b_d;
      r_q   <= r_d;
      lo_q  <= lo_d;
      sat_q <= sat_d;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_o[l]   = lo_q[NST-1][l];
      sat_o[l] = sat_q[NST-1][l];
    end
  end

endmodule

>>> bench/tb.sv
module tb;
  import rlv_pkg::*;

  localparam int unsigned Frac     = FracBitsDef;
  localparam int unsigned PipeLat  = 51;       // input to output register
  localparam int unsigned DrainPad = PipeLat + 10;
  localparam int unsigned WdLimit  = 20000;    // idle cycles before giving up

  typedef logic signed [255:0] wide_t;

  // one lattice: count in the low bits, then a0_x .. a2_z
  typedef struct packed {
    logic [8:0][31:0] comp;
    logic [1:0]       cnt;
  } lattice_t;

  typedef struct packed {
    logic [8:0][31:0] g;
    status_e          st;
  } recip_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  // local copy of the threshold registers
  logic [30:0] thr_volume, thr_len_sq;

  recip_t recip_q[$];
  int     n_errors;
  int     idle_cycles;
  bit     no_idle;        // when set, neither side inserts random gaps
  int     hold_req;       // bumped by a test to request a long receiver stall
  int     hold_len;

  reciprocal_lattice_vectors_unit #(.FRAC_BITS(Frac)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // ---------------------------------------------------------------------
  // Exact-integer model of the datapath (256-bit two's complement)
  // ---------------------------------------------------------------------
  function automatic logic [255:0] mag(wide_t x);
    return x[255] ? 256'(-x) : 256'(x);
  endfunction

  function automatic void cross3(input wide_t u[3], input wide_t v[3],
                                 output wide_t r[3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // round(2*pi * n * 2^(2F) / d), ties away from zero, saturated to 32 bits
  function automatic logic [31:0] scaled_quot(wide_t n, wide_t d);
    logic [255:0] num, den, q;
    logic neg;
    neg = n[255] ^ d[255];
    num = (mag(n) * 256'(TwoPiQ60)) << (2 * Frac + 1);
    den = mag(d) << 60;
    q   = (num + den) / (den << 1);
    if (neg) begin
      if (q > 256'h8000_0000) return 32'h8000_0000;
      return 32'(-q[31:0]);
    end
    if (q > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic recip_t predict_recip(lattice_t it);
    recip_t r;
    wide_t a0[3], a1[3], a2[3], c0[3], c1[3], c2[3];
    wide_t d;
    int unsigned sh;
    r.st = ST_OK;
    r.g  = '0;
    for (int k = 0; k < 3; k++) begin
      a0[k] = wide_t'($signed(it.comp[k]));
      a1[k] = wide_t'($signed(it.comp[3 + k]));
      a2[k] = wide_t'($signed(it.comp[6 + k]));
    end
    if (it.cnt == 2'd0) begin
      r.st = ST_EMPTY;
    end else if (it.cnt == 2'd1) begin
      d = dot3(a0, a0);
      if (mag(d) < ((256'(thr_len_sq) + 1) << Frac)) begin
        r.st = ST_DEGEN;
      end else begin
        for (int k = 0; k < 3; k++) r.g[k] = scaled_quot(a0[k], d);
      end
    end else begin
      sh = 2 * Frac;
      if (it.cnt == 2'd2) begin
        // missing third vector is a0 x a1, kept at full width
        cross3(a0, a1, a2);
        sh = 3 * Frac;
      end
      cross3(a1, a2, c0);
      cross3(a2, a0, c1);
      d = dot3(a0, c0);
      if (mag(d) < ((256'(thr_volume) + 1) << sh)) begin
        r.st = ST_DEGEN;
      end else begin
        for (int k = 0; k < 3; k++) begin
          r.g[k]     = scaled_quot(c0[k], d);
          r.g[3 + k] = scaled_quot(c1[k], d);
        end
        if (it.cnt == 2'd3) begin
          cross3(a0, a1, c2);
          for (int k = 0; k < 3; k++) r.g[6 + k] = scaled_quot(c2[k], d);
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then long
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 96) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one lattice per transaction, prediction taken at acceptance
  // ---------------------------------------------------------------------
  task automatic send_lattice(lattice_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DataW'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    recip_q.push_back(predict_recip(it));
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    @(posedge clk_i);
  endtask

  // waits for the pipe to empty, then writes one threshold register
  task automatic write_thresh(reg_idx_e idx, logic [30:0] val);
    while (recip_q.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_MIN_VOLUME) thr_volume = val;
    else                       thr_len_sq = val;
  endtask

  task automatic set_thresholds(logic [30:0] vol, logic [30:0] len_sq);
    write_thresh(REG_MIN_VOLUME, vol);
    write_thresh(REG_MIN_LEN_SQ, len_sq);
  endtask

  // ---------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_comp();
    int p;
    p = $urandom_range(99);
    if (p < 15) return $urandom();
    if (p < 70) return 32'($signed($urandom_range(1 << 19, 0)) - (1 << 18));
    if (p < 90) return 32'($signed($urandom_range(1 << 9, 0)) - (1 << 8));
    if (p < 95) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom_range(1) ? 32'd0 : 32'h0001_0000;
  endfunction

  function automatic lattice_t rand_lattice();
    lattice_t it;
    int p;
    it.cnt = 2'($urandom_range(3));
    for (int i = 0; i < 9; i++) it.comp[i] = rand_comp();
    p = $urandom_range(99);
    // some near-flat cells: a2 = a0 (+ small nudge) or a1 = -a0
    if (p < 8) begin
      for (int k = 0; k < 3; k++) it.comp[6 + k] = it.comp[k] + 32'($urandom_range(3));
    end else if (p < 12) begin
      for (int k = 0; k < 3; k++) it.comp[3 + k] = -it.comp[k];
    end
    return it;
  endfunction

  function automatic lattice_t mk(logic [1:0] cnt, logic [31:0] a0x, logic [31:0] a0y,
                                  logic [31:0] a0z, logic [31:0] a1x, logic [31:0] a1y,
                                  logic [31:0] a1z, logic [31:0] a2x, logic [31:0] a2y,
                                  logic [31:0] a2z);
    lattice_t it;
    it.cnt  = cnt;
    it.comp = {a2z, a2y, a2x, a1z, a1y, a1x, a0z, a0y, a0x};
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  localparam logic [31:0] One  = 32'h0001_0000;
  localparam logic [31:0] NOne = 32'hFFFF_0000;
  localparam logic [31:0] Max  = 32'h7FFF_FFFF;
  localparam logic [31:0] Min  = 32'h8000_0000;

  task automatic test_directed();
    // empty item, with garbage in every component
    send_lattice(mk(2'd0, Max, Min, One, 1, 2, 3, 4, 5, 6));
    // single vector: unit, scaled, unused inputs ignored
    send_lattice(mk(2'd1, One, 0, 0, Max, Max, Max, Min, Min, Min));
    send_lattice(mk(2'd1, 32'h0003_0000, NOne, 32'h0002_8000, 0, 0, 0, 0, 0, 0));
    // single vector, tiny raw values: one under the length threshold, one above
    send_lattice(mk(2'd1, 32'd1, 32'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    send_lattice(mk(2'd1, 32'd300, 32'hFFFF_FED4, 32'd0, 0, 0, 0, 0, 0, 0));
    // single vector, degenerate length
    send_lattice(mk(2'd1, 0, 0, 0, One, One, One, One, One, One));
    send_lattice(mk(2'd1, 32'd0, 32'd1, 32'd0, 0, 0, 0, 0, 0, 0));
    // single vector at the extremes
    send_lattice(mk(2'd1, Max, Max, Max, 0, 0, 0, 0, 0, 0));
    send_lattice(mk(2'd1, Min, Min, Min, 0, 0, 0, 0, 0, 0));
    // two vectors: orthogonal, skewed, parallel (degenerate), extremes
    send_lattice(mk(2'd2, One, 0, 0, 0, One, 0, Max, Min, Max));
    send_lattice(mk(2'd2, 32'h0002_0000, 32'h0000_8000, 0, NOne, One, 32'h0000_4000,
                    0, 0, 0));
    send_lattice(mk(2'd2, One, One, 0, 32'h0002_0000, 32'h0002_0000, 0, 0, 0, 0));
    send_lattice(mk(2'd2, Max, Min, Max, Min, Max, Min, 0, 0, 0));
    // three vectors: identity, general, flat (degenerate), negated identity, extremes, tiny (degenerate)
    send_lattice(mk(2'd3, One, 0, 0, 0, One, 0, 0, 0, One));
    send_lattice(mk(2'd3, 32'h0004_0000, 0, 0, 32'h0002_0000, 32'h0003_7B00, 0,
                    0, 0, 32'h0006_8000));
    send_lattice(mk(2'd3, One, 0, 0, 0, One, 0, One, One, 0));
    send_lattice(mk(2'd3, NOne, 0, 0, 0, NOne, 0, 0, 0, NOne));
    send_lattice(mk(2'd3, Max, 0, 0, 0, Max, 0, 0, 0, Max));
    send_lattice(mk(2'd3, Min, Max, Min, Max, Min, Max, Min, Min, Max));
    send_lattice(mk(2'd3, 32'd1, 0, 0, 0, 32'd1, 0, 0, 0, 32'd1));
    end_burst();
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) send_lattice(rand_lattice());
    end_burst();
  endtask

  // thresholds at zero, at full scale and at random settings
  task automatic test_thresholds();
    set_thresholds(31'd0, 31'd0);
    test_random(150);
    set_thresholds(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    test_random(150);
    for (int s = 0; s < 4; s++) begin
      set_thresholds(31'($urandom()), 31'($urandom()));
      test_random(150);
    end
    // moderate values so both outcomes show up often
    set_thresholds(31'($urandom_range(1 << 20)), 31'($urandom_range(1 << 20)));
    test_random(200);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    no_idle  = 1'b1;
    hold_len = 400;
    hold_req = hold_req + 1;
    test_random(200);
    no_idle  = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Receiver ready: random stalls, plus long hold-off on request
  // ---------------------------------------------------------------------
  int hold_seen;
  int rx_cnt;
  bit rx_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 0;
      rx_cnt        <= 0;
      rx_stall      <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen     <= hold_req;
      rx_cnt        <= hold_len;
      rx_stall      <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (rx_cnt > 0) begin
      rx_cnt        <= rx_cnt - 1;
      m_axis_tready <= !rx_stall;
    end else if (no_idle && !rx_stall) begin
      m_axis_tready <= 1'b1;
    end else begin
      // pick a new run: ready stretch or a stall
      rx_stall      <= !no_idle && ($urandom_range(99) < 35);
      rx_cnt        <= $urandom_range(99) < 4 ? $urandom_range(60, 15)
                                              : $urandom_range(3);
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h (t=%0t)", what, got, want, $time);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    recip_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = recip_t'(m_axis_tdata[$bits(recip_t)-1:0]);
      if (recip_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(got.st), 32'd0);
      end else begin
        want = recip_q.pop_front();
        if (got.st !== want.st) report_mismatch("status", 32'(got.st), 32'(want.st));
        for (int i = 0; i < 9; i++) begin
          if (got.g[i] !== want.g[i])
            report_mismatch($sformatf("g%0d_%s", i / 3, i % 3 == 0 ? "x" :
                            i % 3 == 1 ? "y" : "z"), got.g[i], want.g[i]);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    thr_volume    = 31'd1;
    thr_len_sq    = 31'd1;
    n_errors      = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    hold_req      = 0;
    hold_len      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();     // reset thresholds
    test_random(380);
    test_backpressure();
    test_thresholds();
    set_thresholds(31'd1, 31'd1);
    test_random(150);

    while (recip_q.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
    if (n_errors == 0 && recip_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> reciprocal_lattice_vectors_unit.f
hw/rtl/rlv_pkg.sv
hw/rtl/rlv_mul.sv
hw/rtl/rlv_div.sv
hw/rtl/reciprocal_lattice_vectors_unit.sv
bench/tb.sv
